// File: rtl/core/i2cram_pkg.sv
// Package for the I2C register access master.
// Holds the operation and bus phase encodings and field widths; no dependencies.
package i2cram_pkg;

	localparam int unsigned AddrW = 7;
	localparam int unsigned ByteW = 8;
	localparam int unsigned CntW  = 4;
	localparam int unsigned IdxW  = 2;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_START_SDA = 4'd1,
		PH_START_SCL = 4'd2,
		PH_TX_LOW    = 4'd3,
		PH_TX_HIGH   = 4'd4,
		PH_ACK_LOW   = 4'd5,
		PH_ACK_HIGH  = 4'd6,
		PH_RS_REL    = 4'd7,
		PH_RS_HIGH   = 4'd8,
		PH_RX_LOW    = 4'd9,
		PH_RX_HIGH   = 4'd10,
		PH_NACK_LOW  = 4'd11,
		PH_NACK_HIGH = 4'd12,
		PH_STOP_LOW  = 4'd13,
		PH_STOP_SCL  = 4'd14,
		PH_STOP_SDA  = 4'd15
	} phase_t;

endpackage

// File: rtl/core/i2c_register_access_master_top.sv
// Top level of the I2C register access master: phase sequencer and result register.
// Depends on i2cram_pkg.
//
// Each input beat is a write command, a read command or one bus phase tick carrying
// the sampled SDA level; every beat yields one result beat with the SCL/SDA drive
// levels, busy, done, status and the last read byte. An input beat is handled by the
// combinational phase sequencer and lands in a single output register, so one
// beat is taken per clock whenever that register is empty or being drained. A write
// takes 2 + 3 * 18 + 3 = 59 ticks, a read 2 + 2 * 18 + 2 + 2 + 18 + 16 + 2 + 3 = 81
// ticks; a missing acknowledge ends the transfer with a stop and status 1.
module i2c_register_access_master_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data,   // device_address
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,    // reg_addr[7:0], wr_data[15:8], sda_in[16], zero
	input  logic [1:0]  s_tuser,    // operation[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata     // scl_out, sda_out, busy_res, done_res, status,
	                                // read_byte[12:5], zero
);

	logic [i2cram_pkg::AddrW-1:0] dev_addr_q;
	i2cram_pkg::phase_t           phase_q, phase_d;
	logic [i2cram_pkg::CntW-1:0]  bit_cnt_q, bit_cnt_d, bit_cnt_inc;
	logic [i2cram_pkg::ByteW-1:0] shift_q, shift_d;
	logic [i2cram_pkg::IdxW-1:0]  byte_idx_q, byte_idx_d;
	logic                         is_read_q, is_read_d;
	logic [i2cram_pkg::ByteW-1:0] held_reg_q, held_reg_d;
	logic [i2cram_pkg::ByteW-1:0] held_data_q, held_data_d;
	logic [i2cram_pkg::ByteW-1:0] rx_byte_q, rx_byte_d;
	logic                         nack_q, nack_d;
	logic                         scl_q, scl_d, sda_q, sda_d;
	logic                         done_d, stat_d;
	logic                         in_acc;

	i2cram_pkg::op_t              op;
	logic [i2cram_pkg::ByteW-1:0] in_reg, in_data;
	logic                         in_sda;

	assign op      = i2cram_pkg::op_t'(s_tuser);
	assign in_reg  = s_tdata[7:0];
	assign in_data = s_tdata[15:8];
	assign in_sda  = s_tdata[16];

	assign cfg_ready   = 1'b1;
	assign s_tready    = !m_tvalid || m_tready;
	assign in_acc      = s_tvalid && s_tready;
	assign bit_cnt_inc = bit_cnt_q + 1'b1;

	function automatic logic [i2cram_pkg::ByteW-1:0] byte_to_send(
		input logic [i2cram_pkg::IdxW-1:0]  idx,
		input logic [i2cram_pkg::AddrW-1:0] dev,
		input logic [i2cram_pkg::ByteW-1:0] reg_b,
		input logic [i2cram_pkg::ByteW-1:0] data_b,
		input logic                         rd
	);
		logic [i2cram_pkg::ByteW-1:0] a;
		a = {dev, 1'b0};
		if (idx == 2'd0) begin
			return a;
		end else if (idx == 2'd1) begin
			return reg_b;
		end else begin
			return rd ? (a | 8'h01) : data_b;
		end
	endfunction

	always_comb begin
		phase_d     = phase_q;
		bit_cnt_d   = bit_cnt_q;
		shift_d     = shift_q;
		byte_idx_d  = byte_idx_q;
		is_read_d   = is_read_q;
		held_reg_d  = held_reg_q;
		held_data_d = held_data_q;
		rx_byte_d   = rx_byte_q;
		nack_d      = nack_q;
		scl_d       = scl_q;
		sda_d       = sda_q;
		done_d      = 1'b0;
		stat_d      = 1'b0;
		if (phase_q == i2cram_pkg::PH_IDLE) begin
			if (op == i2cram_pkg::OP_WRITE || op == i2cram_pkg::OP_READ) begin
				held_reg_d  = in_reg;
				held_data_d = in_data;
				is_read_d   = (op == i2cram_pkg::OP_READ);
				byte_idx_d  = '0;
				bit_cnt_d   = '0;
				nack_d      = 1'b0;
				phase_d     = i2cram_pkg::PH_START_SDA;
			end
		end else if (op == i2cram_pkg::OP_TICK) begin
			unique case (phase_q)
				i2cram_pkg::PH_START_SDA: begin
					scl_d   = 1'b1;
					sda_d   = 1'b0;
					phase_d = i2cram_pkg::PH_START_SCL;
				end
				i2cram_pkg::PH_START_SCL: begin
					scl_d     = 1'b0;
					sda_d     = 1'b0;
					shift_d   = byte_to_send(byte_idx_q, dev_addr_q, held_reg_q,
						held_data_q, is_read_q);
					bit_cnt_d = '0;
					phase_d   = i2cram_pkg::PH_TX_LOW;
				end
				i2cram_pkg::PH_TX_LOW: begin
					scl_d   = 1'b0;
					sda_d   = shift_q[7];
					phase_d = i2cram_pkg::PH_TX_HIGH;
				end
				i2cram_pkg::PH_TX_HIGH: begin
					scl_d     = 1'b1;
					shift_d   = {shift_q[6:0], 1'b0};
					bit_cnt_d = bit_cnt_inc;
					phase_d   = (bit_cnt_inc >= 4'd8) ? i2cram_pkg::PH_ACK_LOW
						: i2cram_pkg::PH_TX_LOW;
				end
				i2cram_pkg::PH_ACK_LOW: begin
					scl_d   = 1'b0;
					sda_d   = 1'b1;
					phase_d = i2cram_pkg::PH_ACK_HIGH;
				end
				i2cram_pkg::PH_ACK_HIGH: begin
					scl_d = 1'b1;
					sda_d = 1'b1;
					if (in_sda) begin
						nack_d  = 1'b1;
						phase_d = i2cram_pkg::PH_STOP_LOW;
					end else if (byte_idx_q == 2'd0 || (byte_idx_q == 2'd1 && !is_read_q)) begin
						byte_idx_d = byte_idx_q + 1'b1;
						shift_d    = byte_to_send(byte_idx_q + 1'b1, dev_addr_q, held_reg_q,
							held_data_q, is_read_q);
						bit_cnt_d  = '0;
						phase_d    = i2cram_pkg::PH_TX_LOW;
					end else if (byte_idx_q == 2'd1) begin
						byte_idx_d = 2'd2;
						phase_d    = i2cram_pkg::PH_RS_REL;
					end else if (is_read_q) begin
						byte_idx_d = 2'd3;
						shift_d    = '0;
						bit_cnt_d  = '0;
						phase_d    = i2cram_pkg::PH_RX_LOW;
					end else begin
						phase_d = i2cram_pkg::PH_STOP_LOW;
					end
				end
				i2cram_pkg::PH_RS_REL: begin
					scl_d   = 1'b0;
					sda_d   = 1'b1;
					phase_d = i2cram_pkg::PH_RS_HIGH;
				end
				i2cram_pkg::PH_RS_HIGH: begin
					scl_d   = 1'b1;
					sda_d   = 1'b1;
					phase_d = i2cram_pkg::PH_START_SDA;
				end
				i2cram_pkg::PH_RX_LOW: begin
					scl_d   = 1'b0;
					sda_d   = 1'b1;
					phase_d = i2cram_pkg::PH_RX_HIGH;
				end
				i2cram_pkg::PH_RX_HIGH: begin
					scl_d     = 1'b1;
					sda_d     = 1'b1;
					shift_d   = {shift_q[6:0], in_sda};
					bit_cnt_d = bit_cnt_inc;
					phase_d   = (bit_cnt_inc >= 4'd8) ? i2cram_pkg::PH_NACK_LOW
						: i2cram_pkg::PH_RX_LOW;
				end
				i2cram_pkg::PH_NACK_LOW: begin
					scl_d   = 1'b0;
					sda_d   = 1'b1;
					phase_d = i2cram_pkg::PH_NACK_HIGH;
				end
				i2cram_pkg::PH_NACK_HIGH: begin
					scl_d   = 1'b1;
					sda_d   = 1'b1;
					phase_d = i2cram_pkg::PH_STOP_LOW;
				end
				i2cram_pkg::PH_STOP_LOW: begin
					scl_d   = 1'b0;
					sda_d   = 1'b0;
					phase_d = i2cram_pkg::PH_STOP_SCL;
				end
				i2cram_pkg::PH_STOP_SCL: begin
					scl_d   = 1'b1;
					sda_d   = 1'b0;
					phase_d = i2cram_pkg::PH_STOP_SDA;
				end
				i2cram_pkg::PH_STOP_SDA: begin
					scl_d  = 1'b1;
					sda_d  = 1'b1;
					done_d = 1'b1;
					stat_d = nack_q;
					if (is_read_q && !nack_q) begin
						rx_byte_d = shift_q;
					end
					phase_d = i2cram_pkg::PH_IDLE;
				end
				default: begin
					scl_d   = 1'b1;
					sda_d   = 1'b1;
					phase_d = i2cram_pkg::PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= 7'h68;
		end else if (cfg_valid && cfg_ready) begin
			dev_addr_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= i2cram_pkg::PH_IDLE;
			bit_cnt_q   <= '0;
			shift_q     <= '0;
			byte_idx_q  <= '0;
			is_read_q   <= 1'b0;
			held_reg_q  <= '0;
			held_data_q <= '0;
			rx_byte_q   <= '0;
			nack_q      <= 1'b0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
		end else if (in_acc) begin
			phase_q     <= phase_d;
			bit_cnt_q   <= bit_cnt_d;
			shift_q     <= shift_d;
			byte_idx_q  <= byte_idx_d;
			is_read_q   <= is_read_d;
			held_reg_q  <= held_reg_d;
			held_data_q <= held_data_d;
			rx_byte_q   <= rx_byte_d;
			nack_q      <= nack_d;
			scl_q       <= scl_d;
			sda_q       <= sda_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (in_acc) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			m_tdata <= {3'b000, rx_byte_d, stat_d, done_d,
				(phase_d != i2cram_pkg::PH_IDLE), sda_d, scl_d};
		end
	end

`ifndef ASSERT_OFF
	a_idle_released: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == i2cram_pkg::PH_IDLE |-> scl_q && sda_q)
		else $error("lines not released while idle");

	a_bit_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_cnt_q <= 4'd8)
		else $error("bit counter out of range");

	a_rx_only_read: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == i2cram_pkg::PH_RX_LOW || phase_q == i2cram_pkg::PH_RX_HIGH
		|| phase_q == i2cram_pkg::PH_RS_REL) |-> is_read_q)
		else $error("receive phase in a write transfer");

	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && done_d |=> phase_q == i2cram_pkg::PH_IDLE && m_tvalid && !m_tdata[2])
		else $error("done beat without return to idle");

	a_status_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[4] |-> m_tdata[3])
		else $error("status set without done");
`endif

endmodule

// File: bench/tb_i2c_register_access_master_top.sv
// Testbench for i2c_register_access_master_top: drives write/read commands and bus ticks,
// predicts every result beat in a scoreboard class and checks it field by field.
// Depends on i2cram_pkg and the RTL top level only.
module tb_i2c_register_access_master_top;
	timeunit 1ns;
	timeprecision 1ps;

	import i2cram_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned RAND_BEATS  = 160;

	typedef struct {
		logic       scl;
		logic       sda;
		logic       busy;
		logic       done;
		logic       status;
		logic [7:0] rd_byte;
	} bus_result_t;

	class i2c_txn_scoreboard;
		logic [6:0]  dev_addr;
		phase_t      phase;
		logic [3:0]  bit_count;
		logic [7:0]  shift_byte;
		logic [2:0]  byte_index;
		logic        is_read;
		logic [7:0]  held_reg;
		logic [7:0]  held_data;
		logic [7:0]  rx_byte;
		logic        nack;
		logic        scl;
		logic        sda;
		bus_result_t expected_q[$];
		int unsigned errors, accepted, checked, commands, completed, nacked, reads_ok;

		function new();
			dev_addr = 7'h68;
			phase = PH_IDLE;
			bit_count = '0;
			shift_byte = '0;
			byte_index = '0;
			is_read = 1'b0;
			held_reg = '0;
			held_data = '0;
			rx_byte = '0;
			nack = 1'b0;
			scl = 1'b1;
			sda = 1'b1;
			errors = 0;
			accepted = 0;
			checked = 0;
			commands = 0;
			completed = 0;
			nacked = 0;
			reads_ok = 0;
		endfunction

		function logic [7:0] next_tx_byte();
			logic [7:0] a;
			a = {dev_addr, 1'b0};
			if (byte_index == 0)
				return a;
			if (byte_index == 1)
				return held_reg;
			return is_read ? (a | 8'h01) : held_data;
		endfunction

		// advance the bus sequencer by one input beat and queue the result
		function void note_beat(op_t op, logic [7:0] ra, logic [7:0] wd, logic sda_in);
			bus_result_t r;
			logic done, stat;
			done = 1'b0;
			stat = 1'b0;
			accepted++;
			if (phase == PH_IDLE) begin
				if (op == OP_WRITE || op == OP_READ) begin
					held_reg = ra;
					held_data = wd;
					is_read = (op == OP_READ);
					byte_index = '0;
					bit_count = '0;
					nack = 1'b0;
					phase = PH_START_SDA;
					commands++;
				end
			end else if (op == OP_TICK) begin
				case (phase)
					PH_START_SDA: begin
						scl = 1'b1; sda = 1'b0;
						phase = PH_START_SCL;
					end
					PH_START_SCL: begin
						scl = 1'b0; sda = 1'b0;
						shift_byte = next_tx_byte();
						bit_count = '0;
						phase = PH_TX_LOW;
					end
					PH_TX_LOW: begin
						scl = 1'b0; sda = shift_byte[7];
						phase = PH_TX_HIGH;
					end
					PH_TX_HIGH: begin
						scl = 1'b1;
						shift_byte = shift_byte << 1;
						bit_count = bit_count + 1'b1;
						phase = (bit_count >= 8) ? PH_ACK_LOW : PH_TX_LOW;
					end
					PH_ACK_LOW: begin
						scl = 1'b0; sda = 1'b1;
						phase = PH_ACK_HIGH;
					end
					PH_ACK_HIGH: begin
						scl = 1'b1; sda = 1'b1;
						if (sda_in) begin
							nack = 1'b1;
							phase = PH_STOP_LOW;
						end else if (byte_index == 0 || (byte_index == 1 && !is_read)) begin
							byte_index = byte_index + 1'b1;
							shift_byte = next_tx_byte();
							bit_count = '0;
							phase = PH_TX_LOW;
						end else if (byte_index == 1) begin
							byte_index = 3'd2;
							phase = PH_RS_REL;
						end else if (is_read) begin
							byte_index = 3'd3;
							shift_byte = '0;
							bit_count = '0;
							phase = PH_RX_LOW;
						end else begin
							phase = PH_STOP_LOW;
						end
					end
					PH_RS_REL: begin
						scl = 1'b0; sda = 1'b1;
						phase = PH_RS_HIGH;
					end
					PH_RS_HIGH: begin
						scl = 1'b1; sda = 1'b1;
						phase = PH_START_SDA;
					end
					PH_RX_LOW: begin
						scl = 1'b0; sda = 1'b1;
						phase = PH_RX_HIGH;
					end
					PH_RX_HIGH: begin
						scl = 1'b1; sda = 1'b1;
						shift_byte = {shift_byte[6:0], sda_in};
						bit_count = bit_count + 1'b1;
						phase = (bit_count >= 8) ? PH_NACK_LOW : PH_RX_LOW;
					end
					PH_NACK_LOW: begin
						scl = 1'b0; sda = 1'b1;
						phase = PH_NACK_HIGH;
					end
					PH_NACK_HIGH: begin
						scl = 1'b1; sda = 1'b1;
						phase = PH_STOP_LOW;
					end
					PH_STOP_LOW: begin
						scl = 1'b0; sda = 1'b0;
						phase = PH_STOP_SCL;
					end
					PH_STOP_SCL: begin
						scl = 1'b1; sda = 1'b0;
						phase = PH_STOP_SDA;
					end
					PH_STOP_SDA: begin
						scl = 1'b1; sda = 1'b1;
						done = 1'b1;
						stat = nack;
						completed++;
						if (nack)
							nacked++;
						if (is_read && !nack) begin
							rx_byte = shift_byte;
							reads_ok++;
						end
						phase = PH_IDLE;
					end
					default: begin
						scl = 1'b1; sda = 1'b1;
						phase = PH_IDLE;
					end
				endcase
			end
			r.scl = scl;
			r.sda = sda;
			r.busy = (phase != PH_IDLE);
			r.done = done;
			r.status = stat;
			r.rd_byte = rx_byte;
			expected_q.push_back(r);
		endfunction

		function void cmp_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_beat(logic [15:0] beat);
			bus_result_t r;
			if (expected_q.size() == 0) begin
				$error("result beat %04h with nothing expected", beat);
				errors++;
				return;
			end
			r = expected_q.pop_front();
			checked++;
			cmp_field("scl_out", r.scl, beat[0]);
			cmp_field("sda_out", r.sda, beat[1]);
			cmp_field("busy_res", r.busy, beat[2]);
			cmp_field("done_res", r.done, beat[3]);
			cmp_field("status", r.status, beat[4]);
			cmp_field("read_byte", r.rd_byte, beat[12:5]);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [6:0]  cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;   // reg_addr[7:0], wr_data[15:8], sda_in[16], zero
	logic [1:0]  s_tuser = '0;   // operation[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // scl_out, sda_out, busy_res, done_res, status,
	                             // read_byte[12:5], zero
	bit          quiet = 1'b0;
	int unsigned cycles = 0;

	i2c_txn_scoreboard sb = new();

	i2c_register_access_master_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// result side: check accepted beats, stall at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_beat(m_tdata);
			m_tready <= quiet || ($urandom_range(99) >= 25);
		end
	end

	task automatic send_beat(op_t op, logic [7:0] ra, logic [7:0] wd, logic sda_in);
		if (!quiet && $urandom_range(99) < 25) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {7'b0, sda_in, wd, ra};
		do @(posedge clk); while (!s_tready);
		sb.note_beat(op, ra, wd, sda_in);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_address(logic [6:0] a);
		cfg_valid <= 1'b1;
		cfg_data <= a;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.dev_addr = a;
	endtask

	// one command and the ticks that carry it to its stop; the slave side
	// acks every byte except nack_byte and returns rx on a read
	task automatic run_txn(op_t op, logic [7:0] ra, logic [7:0] wd, int nack_byte,
	                       logic [7:0] rx, int noise_pct, bit swap, logic [6:0] swap_addr);
		logic s;
		bit   swapped;
		swapped = 1'b0;
		send_beat(op, ra, wd, 1'($urandom_range(1)));
		do begin
			if (swap && !swapped && sb.phase == PH_RS_REL) begin
				drain();
				write_address(swap_addr);
				swapped = 1'b1;
			end
			if ($urandom_range(99) < noise_pct) begin
				send_beat(op_t'($urandom_range(1, 3)), 8'($urandom_range(255)),
				          8'($urandom_range(255)), 1'($urandom_range(1)));
			end else begin
				case (sb.phase)
					PH_ACK_HIGH: s = (int'(sb.byte_index) == nack_byte);
					PH_RX_HIGH:  s = rx[7 - int'(sb.bit_count)];
					default:     s = 1'($urandom_range(1));
				endcase
				send_beat(OP_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)), s);
			end
		end while (sb.phase != PH_IDLE);
	endtask

	initial begin
		int unsigned base;
		logic [6:0]  addr;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle ticks, unused opcode, then transfers at the extremes
		send_beat(OP_TICK, 8'h00, 8'h00, 1'b0);
		send_beat(OP_TICK, 8'hFF, 8'hFF, 1'b1);
		send_beat(OP_NONE, 8'hA5, 8'h5A, 1'b1);
		run_txn(OP_WRITE, 8'hFF, 8'h00, 3, 8'h00, 30, 1'b0, 7'h00);
		run_txn(OP_READ, 8'h00, 8'hFF, 3, 8'hFF, 0, 1'b1, 7'h7F);
		run_txn(OP_READ, 8'h3C, 8'h00, 2, 8'hC3, 0, 1'b0, 7'h00);
		run_txn(OP_WRITE, 8'h01, 8'hFF, 0, 8'h00, 0, 1'b0, 7'h00);
		run_txn(OP_WRITE, 8'h7F, 8'h81, 2, 8'h00, 0, 1'b0, 7'h00);
		run_txn(OP_READ, 8'hC0, 8'h00, 1, 8'h00, 0, 1'b0, 7'h00);

		base = sb.accepted;
		for (int ph = 0; ph < 4; ph++) begin
			drain();
			case (ph)
				0:       addr = 7'h00;
				2:       addr = 7'h7F;
				default: addr = 7'($urandom_range(127));
			endcase
			write_address(addr);
			quiet = (ph == 2);
			do begin
				if ($urandom_range(99) < 30) begin
					repeat ($urandom_range(1, 3))
						send_beat($urandom_range(1) ? OP_TICK : OP_NONE,
						          8'($urandom_range(255)), 8'($urandom_range(255)),
						          1'($urandom_range(1)));
				end
				run_txn($urandom_range(1) ? OP_READ : OP_WRITE, 8'($urandom_range(255)),
				        8'($urandom_range(255)),
				        ($urandom_range(99) < 65) ? 3 : int'($urandom_range(2)),
				        8'($urandom_range(255)), 3, 1'b0, 7'h00);
			end while (sb.accepted < base + (RAND_BEATS / 4) * (ph + 1));
		end
		quiet = 1'b0;

		drain();
		repeat (8) @(posedge clk);
		$display("tb: %0d beats in, %0d results checked, %0d transfers started",
		         sb.accepted, sb.checked, sb.commands);
		$display("tb: %0d stops, %0d ended on a missing ack, %0d good reads, %0d errors",
		         sb.completed, sb.nacked, sb.reads_ok, sb.errors);
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

// File: sim.f
rtl/core/i2cram_pkg.sv
rtl/core/i2c_register_access_master_top.sv
bench/tb_i2c_register_access_master_top.sv
